[design/circular_deque_macros.svh]
// ---------------------------------------------------------------------------
// circular_deque_macros.svh
// Assertion shorthands for the circular deque checker.
// ---------------------------------------------------------------------------
// The expanding scope must provide i_clk and i_rst_n.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("circular deque check failed");

// Consequent must hold in the cycle after the antecedent.
`define CD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("circular deque check failed");

`endif

[design/cd_pkg.sv]
// ---------------------------------------------------------------------------
// cd_pkg
// Types and codes shared by the circular deque ring cells and control.
// ---------------------------------------------------------------------------
package cd_pkg;

    localparam int WORD_W = 32;

    // Operation codes carried on the op input.
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Movement of the whole ring.
    typedef enum logic [1:0] {
        SHIFT_HOLD  = 2'd0,
        SHIFT_LEFT  = 2'd1,
        SHIFT_RIGHT = 2'd2
    } t_shift;

    // Per-cell control: ring movement plus a load of the input word.
    typedef struct packed {
        t_shift shift;
        logic   load;
    } t_cell_ctrl;

endpackage

[design/cd_cell.sv]
// ---------------------------------------------------------------------------
// cd_cell
// One storage cell of the rotating ring; takes a neighbor's word or a load.
// ---------------------------------------------------------------------------
module cd_cell (
    input  logic                               i_clk,
    input  cd_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [cd_pkg::WORD_W-1:0]   i_load_value,
    input  logic signed [cd_pkg::WORD_W-1:0]   i_from_prev,
    input  logic signed [cd_pkg::WORD_W-1:0]   i_from_next,
    output logic signed [cd_pkg::WORD_W-1:0]   o_word
);

    logic signed [cd_pkg::WORD_W-1:0] r_word;
    logic signed [cd_pkg::WORD_W-1:0] n_word;

    // A left shift pulls from the higher neighbor, a right shift from the lower.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.load) begin
            n_word = i_load_value;
        end else begin
            case (i_ctrl.shift)
                cd_pkg::SHIFT_HOLD:  n_word = r_word;
                cd_pkg::SHIFT_LEFT:  n_word = i_from_next;
                cd_pkg::SHIFT_RIGHT: n_word = i_from_prev;
                default:             n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[design/circular_deque.sv]
// ---------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed words held in a rotating ring of cells.
// ---------------------------------------------------------------------------
// Usage: drive i_op and i_push_value with start high; the beat is taken at a
// rising edge where start is high and busy is low. Every accepted beat gives
// exactly one result beat on o_pop_value and o_status, marked by o_valid for
// a single cycle. The receiver cannot stall, so results are never held.
//
// The words live in a ring of DEPTH cells and only cell 0 is ever read or
// loaded. The ring is kept aligned to one end of the queue: either the front
// word or the back word sits in cell 0. An operation on the aligned end (or
// any operation while the queue holds at most one word, or any refused one)
// completes at once and its result appears on the next cycle, so such
// beats may be issued back to back.
//
// An operation on the other end first rotates the ring one cell per cycle
// until that end reaches cell 0: the accepting cycle latches the beat and
// enters the align state, which rotates the ring and then completes the
// operation. Busy is high throughout the align state, and the result
// appears in the cycle after the operation completes.
//
// Reset (i_rst_n low, synchronous) empties the queue and aligns the front.
// The cell contents are not cleared; a word is only read after it was pushed.
// ---------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_op,
    input  logic signed [cd_pkg::WORD_W-1:0]   i_push_value,
    output logic                               o_valid,
    output logic signed [cd_pkg::WORD_W-1:0]   o_pop_value,
    output logic [1:0]                         o_status
);

    // The fill count must be able to hold DEPTH itself.
    localparam int CntW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_ALIGN
    } t_state;

    t_state                              r_state;
    logic [CntW-1:0]                     r_count;
    logic [CntW-1:0]                     r_steps;
    // High when the back word sits in cell 0, low when the front word does.
    logic                                r_back_mode;
    cd_pkg::t_op                         r_op;
    logic signed [cd_pkg::WORD_W-1:0]    r_value;
    logic                                r_valid;
    logic signed [cd_pkg::WORD_W-1:0]    r_pop_value;
    cd_pkg::t_status                     r_status;

    logic                                w_accept;
    cd_pkg::t_op                         w_op;
    logic signed [cd_pkg::WORD_W-1:0]    w_value;
    logic                                w_is_push;
    logic                                w_is_back;
    logic                                w_full;
    logic                                w_empty;
    logic                                w_refused;
    logic                                w_need_switch;
    logic                                w_exec;
    cd_pkg::t_shift                      w_shift;
    logic                                w_load;
    logic signed [cd_pkg::WORD_W-1:0]    w_word [DEPTH];
    cd_pkg::t_cell_ctrl                  w_cell_ctrl [DEPTH];

    assign busy     = (r_state == S_ALIGN);
    assign w_accept = start && !busy;

    // While rotating, the operation comes from the latched copy.
    assign w_op    = (r_state == S_ALIGN) ? r_op : cd_pkg::t_op'(i_op);
    assign w_value = (r_state == S_ALIGN) ? r_value : i_push_value;

    assign w_is_push = (w_op == cd_pkg::OP_PUSH_FRONT) || (w_op == cd_pkg::OP_PUSH_BACK);
    assign w_is_back = (w_op == cd_pkg::OP_PUSH_BACK) || (w_op == cd_pkg::OP_POP_BACK);
    assign w_full    = (r_count == CntW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_refused = w_is_push ? w_full : w_empty;

    // With one word or none, cell 0 already serves both ends.
    assign w_need_switch = (w_is_back != r_back_mode) && (r_count > CntW'(1)) && !w_refused;

    assign w_exec = (w_accept && !w_need_switch) || ((r_state == S_ALIGN) && (r_steps == '0));

    // Ring movement. Front aligned: the queue runs upward from cell 0, so a
    // front push rotates right and a front pop rotates left. Back aligned:
    // the queue runs downward from cell 0 and the directions swap.
    always_comb begin
        w_shift = cd_pkg::SHIFT_HOLD;
        w_load  = 1'b0;
        if ((r_state == S_ALIGN) && (r_steps != '0)) begin
            w_shift = r_back_mode ? cd_pkg::SHIFT_RIGHT : cd_pkg::SHIFT_LEFT;
        end else if (w_exec && !w_refused) begin
            case (w_op)
                cd_pkg::OP_PUSH_FRONT: begin
                    w_shift = cd_pkg::SHIFT_RIGHT;
                    w_load  = 1'b1;
                end
                cd_pkg::OP_PUSH_BACK: begin
                    w_shift = cd_pkg::SHIFT_LEFT;
                    w_load  = 1'b1;
                end
                cd_pkg::OP_POP_FRONT: w_shift = cd_pkg::SHIFT_LEFT;
                cd_pkg::OP_POP_BACK:  w_shift = cd_pkg::SHIFT_RIGHT;
                default:              w_shift = cd_pkg::SHIFT_HOLD;
            endcase
        end
    end

    // The ring of cells. Every cell moves together; only cell 0 loads.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int Prev = (g == 0) ? DEPTH - 1 : g - 1;
        localparam int Next = (g == DEPTH - 1) ? 0 : g + 1;

        assign w_cell_ctrl[g].shift = w_shift;
        assign w_cell_ctrl[g].load  = (g == 0) ? w_load : 1'b0;

        cd_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_cell_ctrl[g]),
            .i_load_value (w_value),
            .i_from_prev  (w_word[Prev]),
            .i_from_next  (w_word[Next]),
            .o_word       (w_word[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_back_mode <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= w_exec;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= cd_pkg::t_op'(i_op);
                        r_value <= i_push_value;
                        if (w_need_switch) begin
                            r_state <= S_ALIGN;
                            r_steps <= r_count - CntW'(1);
                        end
                    end
                end
                S_ALIGN: begin
                    if (r_steps != '0) begin
                        r_steps <= r_steps - CntW'(1);
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_exec) begin
                if (w_refused) begin
                    r_status    <= w_is_push ? cd_pkg::ST_FULL : cd_pkg::ST_EMPTY;
                    r_pop_value <= '0;
                end else begin
                    r_status    <= cd_pkg::ST_DONE;
                    r_pop_value <= w_is_push ? '0 : w_word[0];
                    r_back_mode <= w_is_back;
                    if (w_is_push) begin
                        r_count <= r_count + CntW'(1);
                    end else begin
                        r_count <= r_count - CntW'(1);
                    end
                end
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule

[design/cd_checker.sv]
// ---------------------------------------------------------------------------
// cd_checker
// Port-level timing checks for the circular deque, bound to the top level.
// ---------------------------------------------------------------------------
`include "circular_deque_macros.svh"

module cd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [cd_pkg::WORD_W-1:0]   o_pop_value,
    input logic [1:0]                         o_status
);

    logic w_refusal;

    // A result beat that reports a refused operation.
    assign w_refusal = o_valid && (o_status != cd_pkg::ST_DONE);

    // An accepted beat either completes at once or holds the block busy.
    `CD_ASSERT_NEXT(a_accept_answered, start && !busy, busy || o_valid)

    // A result always ends the alignment walk.
    `CD_ASSERT_SAME(a_valid_not_busy, o_valid, !busy)

    // Refused operations never rotate, so they answer in the next cycle.
    `CD_ASSERT_SAME(a_refusal_prompt, w_refusal, $past(start && !busy))

    // A refused operation returns no data.
    `CD_ASSERT_SAME(a_refusal_zero, w_refusal, o_pop_value == '0)

endmodule

bind circular_deque cd_checker u_cd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_pop_value (o_pop_value),
    .o_status    (o_status)
);

[bench/circular_deque_tb.sv]
// ---------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque: random push and pop beats
// are predicted against a behavioral copy of the deque and every result
// beat is compared field by field.
// ---------------------------------------------------------------------------
module circular_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int RANDOM_BEATS = 1520;

    // One operation waiting to be issued, plus the idle cycles that follow it.
    typedef struct {
        cd_pkg::t_op                      op;
        logic signed [cd_pkg::WORD_W-1:0] word;
        int unsigned                      gap;
    } t_deque_op;

    // One predicted result beat.
    typedef struct {
        logic signed [cd_pkg::WORD_W-1:0] pop_value;
        cd_pkg::t_status                  status;
    } t_deque_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [1:0]                        i_op = cd_pkg::OP_PUSH_FRONT;
    logic signed [cd_pkg::WORD_W-1:0]  i_push_value = '0;
    logic                              o_valid;
    logic signed [cd_pkg::WORD_W-1:0]  o_pop_value;
    logic [1:0]                        o_status;

    circular_deque #(.DEPTH(DEPTH)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Behavioral copy of the deque. The vacancy flag marks the empty queue,
    // so all DEPTH entries can hold words.
    logic signed [cd_pkg::WORD_W-1:0] deque_words [DEPTH];
    logic [PTR_W-1:0]                 front_ptr = '0;
    logic [PTR_W-1:0]                 back_ptr = '0;
    logic                             deque_vacant = 1'b1;

    t_deque_op     pending_ops [$];
    t_deque_result awaited_results [$];

    int unsigned issued_beats = 0;
    int unsigned accepted_beats = 0;
    int unsigned gap_left = 0;
    int unsigned fail_count = 0;

    function automatic logic [PTR_W-1:0] ptr_up(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    // Applies one accepted operation to the deque copy and returns the beat
    // the block must answer with.
    function automatic t_deque_result deque_apply(input cd_pkg::t_op op,
                                                  input logic signed [cd_pkg::WORD_W-1:0] word);
        t_deque_result res;
        res.pop_value = '0;
        res.status    = cd_pkg::ST_DONE;
        if (op == cd_pkg::OP_PUSH_FRONT || op == cd_pkg::OP_PUSH_BACK) begin
            if (!deque_vacant && front_ptr == ptr_up(back_ptr)) begin
                res.status = cd_pkg::ST_FULL;
            end else if (deque_vacant) begin
                // The first word always lands in entry 0, whichever end.
                deque_vacant   = 1'b0;
                front_ptr      = '0;
                back_ptr       = '0;
                deque_words[0] = word;
            end else if (op == cd_pkg::OP_PUSH_FRONT) begin
                front_ptr              = ptr_down(front_ptr);
                deque_words[front_ptr] = word;
            end else begin
                back_ptr              = ptr_up(back_ptr);
                deque_words[back_ptr] = word;
            end
        end else begin
            if (deque_vacant) begin
                res.status = cd_pkg::ST_EMPTY;
            end else begin
                res.pop_value = (op == cd_pkg::OP_POP_FRONT) ? deque_words[front_ptr]
                                                             : deque_words[back_ptr];
                if (front_ptr == back_ptr) begin
                    // Last word gone: the queue is empty again.
                    deque_vacant = 1'b1;
                    front_ptr    = '0;
                    back_ptr     = '0;
                end else if (op == cd_pkg::OP_POP_FRONT) begin
                    front_ptr = ptr_up(front_ptr);
                end else begin
                    back_ptr = ptr_down(back_ptr);
                end
            end
        end
        return res;
    endfunction

    // Driver. Inputs move only on the falling edge. A beat stays on the
    // inputs until the monitor has seen it accepted, then the idle cycles
    // drawn for it are spent before the next one goes out.
    always @(negedge i_clk) begin
        t_deque_op nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && accepted_beats != issued_beats) begin
            // Current beat not taken yet; hold it.
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_ops.size() > 0) begin
            nxt           = pending_ops.pop_front();
            start         <= 1'b1;
            i_op          <= nxt.op;
            i_push_value  <= nxt.word;
            gap_left      <= nxt.gap;
            issued_beats  <= issued_beats + 1;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor. Sampled on the rising edge, so every read sees the values
    // that were settled before the edge. Result beats are checked against
    // the oldest prediction first; an accepted beat then adds its own.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                fail_count += 1;
                $display("%0t: result beat with nothing awaited: pop_value %0d status %0d",
                         $time, o_pop_value, o_status);
            end else begin
                want = awaited_results.pop_front();
                if (o_pop_value !== want.pop_value) begin
                    fail_count += 1;
                    $display("%0t: pop_value expected %0d actual %0d",
                             $time, want.pop_value, o_pop_value);
                end
                if (o_status !== want.status) begin
                    fail_count += 1;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            awaited_results.push_back(deque_apply(cd_pkg::t_op'(i_op), i_push_value));
            accepted_beats <= accepted_beats + 1;
        end
    end

    task automatic queue_op(input cd_pkg::t_op op,
                            input logic signed [cd_pkg::WORD_W-1:0] word,
                            input int unsigned gap);
        t_deque_op item;
        item.op   = op;
        item.word = word;
        item.gap  = gap;
        pending_ops.push_back(item);
    endtask

    // Words for random pushes: mostly uniform, now and then an extreme.
    function automatic logic signed [cd_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int unsigned made;
        int unsigned run_len;
        int unsigned push_pct;
        bit          no_gaps;
        cd_pkg::t_op op;

        // Directed opening: pops on the empty queue, the first word pushed
        // from either end, popping the last word, then a fill to the brim
        // with pushes refused on the full queue, then a pop from each end.
        queue_op(cd_pkg::OP_POP_FRONT, 32'sh1234_5678, 0);
        queue_op(cd_pkg::OP_POP_BACK, -32'sd1, 1);
        queue_op(cd_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF, 0);
        queue_op(cd_pkg::OP_PUSH_BACK, 32'sh8000_0000, 2);
        queue_op(cd_pkg::OP_POP_FRONT, '0, 0);
        queue_op(cd_pkg::OP_POP_FRONT, '0, 0);
        queue_op(cd_pkg::OP_POP_BACK, '0, 0);
        queue_op(cd_pkg::OP_PUSH_BACK, -32'sd1, 0);
        queue_op(cd_pkg::OP_POP_BACK, '0, 3);
        for (int k = 0; k < DEPTH; k++) begin
            queue_op((k % 2) ? cd_pkg::OP_PUSH_FRONT : cd_pkg::OP_PUSH_BACK,
                     (k % 3 == 0) ? 32'sh8000_0000 : 32'(k) * 32'sh1111_1111, 0);
        end
        queue_op(cd_pkg::OP_PUSH_FRONT, 32'sh5A5A_5A5A, 0);
        queue_op(cd_pkg::OP_PUSH_BACK, 32'shA5A5_A5A5, 1);
        queue_op(cd_pkg::OP_POP_BACK, '0, 0);
        queue_op(cd_pkg::OP_POP_FRONT, '0, 4);

        // Random part in runs. Each run leans toward pushes, toward pops or
        // neither, so the queue swings between full and empty again and
        // again; about one run in four issues beats back to back.
        made = 0;
        while (made < RANDOM_BEATS) begin
            run_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run_len; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? cd_pkg::OP_PUSH_BACK : cd_pkg::OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? cd_pkg::OP_POP_BACK : cd_pkg::OP_POP_FRONT;
                queue_op(op, pick_word(), no_gaps ? 0 : $urandom_range(0, 4));
            end
            made += run_len;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Let every beat go out and every result come back, then allow a few
        // rotation times for a stray beat to show up.
        while (pending_ops.size() > 0 || accepted_beats != issued_beats || start)
            @(posedge i_clk);
        while (awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
